FILE: hdl/i2cadc_pkg.sv
// ----------------------------------------------------------------------------
// I2C ADC reader package
// Phase codes, register indexes, reset values and the per-step result type.
// ----------------------------------------------------------------------------
package i2cadc_pkg;

	localparam int PHASE_W = 4;

	localparam logic [PHASE_W-1:0] PH_IDLE   = 4'd0;
	localparam logic [PHASE_W-1:0] PH_START1 = 4'd1;
	localparam logic [PHASE_W-1:0] PH_WADDR1 = 4'd2;
	localparam logic [PHASE_W-1:0] PH_WSETUP = 4'd3;
	localparam logic [PHASE_W-1:0] PH_STOP1  = 4'd4;
	localparam logic [PHASE_W-1:0] PH_START2 = 4'd5;
	localparam logic [PHASE_W-1:0] PH_WADDR2 = 4'd6;
	localparam logic [PHASE_W-1:0] PH_READ   = 4'd7;
	localparam logic [PHASE_W-1:0] PH_STOP2  = 4'd8;

	localparam logic [1:0] REG_WRITE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_READ_ADDRESS  = 2'd1;
	localparam logic [1:0] REG_SETUP_BYTE    = 2'd2;

	localparam logic [7:0] WRITE_ADDRESS_RST = 8'hD0;
	localparam logic [7:0] READ_ADDRESS_RST  = 8'hD1;
	localparam logic [7:0] SETUP_BYTE_RST    = 8'h9C;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// number of result bytes read; storage holds at most four
	localparam int READ_BYTES_DEF = 4;
	localparam int CAP_DEPTH      = 4;

	localparam int TDATA_OUT_W = 40;
	localparam int TDATA_IN_W  = 8;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       ack_missing;
		logic [7:0] data_high;
		logic [7:0] data_middle;
		logic [7:0] data_low;
		logic [7:0] status_value;
		logic       not_ready;
		logic       done_res;
	} res_t;

endpackage

FILE: hdl/i2cadc_seq.sv
// ----------------------------------------------------------------------------
// I2C ADC reader sequencer
// Bus sequence state and its one-step update for a tick or a begin request.
// ----------------------------------------------------------------------------
module i2cadc_seq #(
	parameter int READ_BYTES = i2cadc_pkg::READ_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              func,
	input  logic              sda_in,
	input  logic [7:0]        write_address,
	input  logic [7:0]        read_address,
	input  logic [7:0]        setup_byte,
	output i2cadc_pkg::res_t  res
);
	import i2cadc_pkg::*;

	localparam logic [1:0] LAST_IDX = 2'(READ_BYTES - 1);

	logic [PHASE_W-1:0] phase_q, phase_n;
	logic [1:0]         half_q, half_n;
	logic [3:0]         bitcnt_q, bitcnt_n;
	logic [7:0]         shift_q, shift_n;
	logic [1:0]         byte_q, byte_n;
	logic               ack_q, ack_n;
	logic [7:0]         cap_q [CAP_DEPTH];
	logic [7:0]         cap_n [CAP_DEPTH];
	logic               scl_q, scl_n;
	logic               sda_q, sda_n;
	logic               done;
	logic               last;

	assign last = (byte_q >= LAST_IDX);

	always_comb begin
		phase_n  = phase_q;
		half_n   = half_q;
		bitcnt_n = bitcnt_q;
		shift_n  = shift_q;
		byte_n   = byte_q;
		ack_n    = ack_q;
		cap_n    = cap_q;
		scl_n    = scl_q;
		sda_n    = sda_q;
		done     = 1'b0;
		if (func) begin
			// begin request: ignored while busy
			if (phase_q == PH_IDLE) begin
				phase_n  = PH_START1;
				half_n   = 2'd0;
				bitcnt_n = 4'd0;
				byte_n   = 2'd0;
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
				end
				PH_START1, PH_START2: begin
					if (half_q == 2'd0) begin
						scl_n  = 1'b1;
						sda_n  = 1'b1;
						half_n = 2'd1;
					end else if (half_q == 2'd1) begin
						scl_n  = 1'b1;
						sda_n  = 1'b0;
						half_n = 2'd2;
					end else begin
						scl_n    = 1'b0;
						sda_n    = 1'b0;
						half_n   = 2'd0;
						bitcnt_n = 4'd0;
						if (phase_q == PH_START1) begin
							shift_n = write_address;
							phase_n = PH_WADDR1;
						end else begin
							shift_n = read_address;
							phase_n = PH_WADDR2;
						end
					end
				end
				PH_WADDR1, PH_WSETUP, PH_WADDR2: begin
					if (bitcnt_q < BITS_PER_BYTE) begin
						if (half_q == 2'd0) begin
							scl_n  = 1'b1;
							sda_n  = shift_q[7];
							half_n = 2'd1;
						end else begin
							scl_n    = 1'b0;
							shift_n  = {shift_q[6:0], 1'b0};
							bitcnt_n = bitcnt_q + 4'd1;
							half_n   = 2'd0;
						end
					end else if (half_q == 2'd0) begin
						scl_n  = 1'b1;
						sda_n  = 1'b1;
						half_n = 2'd1;
					end else begin
						// sample the slave acknowledge
						ack_n    = sda_in;
						scl_n    = 1'b0;
						sda_n    = 1'b1;
						half_n   = 2'd0;
						bitcnt_n = 4'd0;
						if (phase_q == PH_WADDR1) begin
							shift_n = setup_byte;
							phase_n = PH_WSETUP;
						end else if (phase_q == PH_WSETUP) begin
							phase_n = PH_STOP1;
						end else begin
							shift_n = 8'd0;
							byte_n  = 2'd0;
							phase_n = PH_READ;
						end
					end
				end
				PH_READ: begin
					if (bitcnt_q < BITS_PER_BYTE) begin
						if (half_q == 2'd0) begin
							scl_n  = 1'b1;
							sda_n  = 1'b1;
							half_n = 2'd1;
						end else begin
							shift_n  = {shift_q[6:0], sda_in};
							scl_n    = 1'b0;
							sda_n    = 1'b1;
							bitcnt_n = bitcnt_q + 4'd1;
							half_n   = 2'd0;
						end
					end else if (half_q == 2'd0) begin
						// master acknowledge, NACK on the last byte
						scl_n  = 1'b1;
						sda_n  = last;
						half_n = 2'd1;
					end else begin
						scl_n         = 1'b0;
						sda_n         = 1'b1;
						cap_n[byte_q] = shift_q;
						shift_n       = 8'd0;
						bitcnt_n      = 4'd0;
						half_n        = 2'd0;
						if (last) begin
							phase_n = PH_STOP2;
						end else begin
							byte_n = byte_q + 2'd1;
						end
					end
				end
				PH_STOP1, PH_STOP2: begin
					if (half_q == 2'd0) begin
						scl_n  = 1'b0;
						sda_n  = 1'b0;
						half_n = 2'd1;
					end else if (half_q == 2'd1) begin
						scl_n  = 1'b1;
						sda_n  = 1'b0;
						half_n = 2'd2;
					end else begin
						scl_n  = 1'b1;
						sda_n  = 1'b1;
						half_n = 2'd0;
						if (phase_q == PH_STOP1) begin
							phase_n = PH_START2;
						end else begin
							phase_n = PH_IDLE;
							done    = 1'b1;
						end
					end
				end
				default: begin
					phase_n = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			half_q   <= 2'd0;
			bitcnt_q <= 4'd0;
			shift_q  <= 8'd0;
			byte_q   <= 2'd0;
			ack_q    <= 1'b0;
			for (int i = 0; i < CAP_DEPTH; i++) begin
				cap_q[i] <= 8'd0;
			end
			scl_q    <= 1'b1;
			sda_q    <= 1'b1;
		end else if (step) begin
			phase_q  <= phase_n;
			half_q   <= half_n;
			bitcnt_q <= bitcnt_n;
			shift_q  <= shift_n;
			byte_q   <= byte_n;
			ack_q    <= ack_n;
			cap_q    <= cap_n;
			scl_q    <= scl_n;
			sda_q    <= sda_n;
		end
	end

	always_comb begin
		res.scl_out      = scl_n;
		res.sda_out      = sda_n;
		res.busy_res     = (phase_n != PH_IDLE);
		res.ack_missing  = ack_n;
		res.data_high    = cap_n[0];
		res.data_middle  = cap_n[1];
		res.data_low     = cap_n[2];
		res.status_value = cap_n[3];
		res.not_ready    = cap_n[3][7];
		res.done_res     = done;
	end

	a_bitcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bitcnt_q <= BITS_PER_BYTE)
		else $error("bit counter past one byte");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && done |=> phase_q == PH_IDLE)
		else $error("done without return to idle");

	a_read_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_READ |-> byte_q <= LAST_IDX)
		else $error("read byte index past last byte");

	a_start_scl_high: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_START1 || phase_q == PH_START2) && half_q != 2'd0 |-> scl_q)
		else $error("SCL low inside start condition");

endmodule

FILE: hdl/i2c_adc_conversion_reader_top.sv
// ----------------------------------------------------------------------------
// I2C ADC conversion reader
// Open-drain I2C master stepping one half-bit per tick request.
//
//  channel   dir  handshake          payload
//  s_*       in   tvalid / tready    tuser = func, tdata[0] = sda_in
//  m_*       out  tvalid / tready    tdata = line levels, flags, result bytes,
//                                    tlast = done_res
//  cfg_*     in   cfg_we             cfg_index, cfg_data
//
// One request per cycle sustained while the output is not stalled; each
// passes from the input register through the sequencer update into the
// result register.
// Reset puts the bus lines released, the sequencer idle and the registers at
// their defaults. A stalled output holds its result while the input register
// still accepts one more request.
// ----------------------------------------------------------------------------
module i2c_adc_conversion_reader_top #(
	parameter int READ_BYTES = i2cadc_pkg::READ_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic                                s_tuser,  // [0] func
	input  logic [i2cadc_pkg::TDATA_IN_W-1:0]   s_tdata,  // [0] sda_in, [7:1] zero
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic                                m_tlast,  // done_res
	// [0] scl_out, [1] sda_out, [2] busy_res, [3] ack_missing,
	// [11:4] data_high, [19:12] data_middle, [27:20] data_low,
	// [35:28] status_value, [36] not_ready, [39:37] zero
	output logic [i2cadc_pkg::TDATA_OUT_W-1:0]  m_tdata,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [7:0]                          cfg_data
);
	import i2cadc_pkg::*;

	logic       valid_s1;
	logic       func_s1;
	logic       sda_s1;
	logic       advance;
	logic [7:0] write_address_q;
	logic [7:0] read_address_q;
	logic [7:0] setup_byte_q;
	res_t       res;
	logic       m_tvalid_q;
	logic       m_tlast_q;
	logic [TDATA_OUT_W-1:0] m_tdata_q;

	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_address_q <= WRITE_ADDRESS_RST;
			read_address_q  <= READ_ADDRESS_RST;
			setup_byte_q    <= SETUP_BYTE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WRITE_ADDRESS: write_address_q <= cfg_data;
				REG_READ_ADDRESS:  read_address_q  <= cfg_data;
				REG_SETUP_BYTE:    setup_byte_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_tuser;
			sda_s1  <= s_tdata[0];
		end
	end

	i2cadc_seq #(
		.READ_BYTES(READ_BYTES)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.func          (func_s1),
		.sda_in        (sda_s1),
		.write_address (write_address_q),
		.read_address  (read_address_q),
		.setup_byte    (setup_byte_q),
		.res           (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tlast_q <= res.done_res;
			m_tdata_q <= {3'b000, res.not_ready, res.status_value, res.data_low,
				res.data_middle, res.data_high, res.ack_missing, res.busy_res,
				res.sda_out, res.scl_out};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = m_tdata_q;

	a_hold_request: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(func_s1) && $stable(sda_s1))
		else $error("pending request lost");

	a_step_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid_q)
		else $error("result register not loaded");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && !m_tready |-> !advance)
		else $error("result overwritten while stalled");

endmodule
